FILE: src/fcvf_pkg.sv
// shared types and constants of the four channel volume fader
// no dependencies
`timescale 1ns / 1ps

package fcvf_pkg;

	localparam int LEVEL_W       = 19;
	localparam int COUNT_W       = 13;
	localparam int DIVISOR_W     = 12;
	localparam int BYTE_W        = 7;
	localparam int FRAMES_W      = 14;
	localparam int TARGET_W      = 19;
	localparam int CFG_INDEX_W   = 2;
	localparam int NUM_CH        = 4;
	localparam int FRAME_LIMIT   = 4095;
	localparam int FRACTION_BITS = 12;

	localparam logic [LEVEL_W-1:0] TARGET_RESET = 19'h7F000;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RR = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RL = 2'd3;

	// input kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef struct packed {
		logic                 start;
		logic [LEVEL_W-1:0]   dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] quot;
		logic               rem_nz;
	} div_rsp_t;

endpackage

FILE: src/fcvf_div.sv
// restoring divider, one quotient bit per cycle, shared by all channels
// depends on fcvf_pkg
`timescale 1ns / 1ps

module fcvf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fcvf_pkg::div_req_t req,
	output fcvf_pkg::div_rsp_t rsp
);

	localparam int LW = fcvf_pkg::LEVEL_W;
	localparam int DW = fcvf_pkg::DIVISOR_W;
	localparam int CW = $clog2(LW);

	logic [LW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] divisor_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[LW-1]};
		rem_sub = rem_sh - {1'b0, divisor_q};
		ge      = rem_sh >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = dvd_q;
	assign rsp.rem_nz = |rem_q;

endmodule

FILE: src/four_channel_volume_fader.sv
// four channel volume fader, top level: sequencer, level registers, output register
// a start transfer gives no result; a frame transfer with no fade running goes straight
// to the emit state; a frame transfer with a fade running steps through each channel in
// turn (load, 19-step divide, level update) and then the emit state; the result is held
// back while an earlier result waits, and the input is not ready again until the emit
// state is left; reset: levels zero, count zero, targets 0x7F000
// depends on fcvf_pkg, fcvf_div
`timescale 1ns / 1ps

module four_channel_volume_fader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] frames, rest zero
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [6:0] out_ll, [13:7] out_lr, [20:14] out_rr,
	                               // [27:21] out_rl, [40:28] frames_left, rest zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [18:0] cfg_data
);

	localparam int LW = fcvf_pkg::LEVEL_W;
	localparam int CW = fcvf_pkg::COUNT_W;
	localparam int NW = fcvf_pkg::DIVISOR_W;
	localparam int BW = fcvf_pkg::BYTE_W;
	localparam int FW = fcvf_pkg::FRAMES_W;
	localparam int NCH = fcvf_pkg::NUM_CH;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DIVW  = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;

	logic [2:0]           state_q;
	logic [1:0]           ch_q;
	logic [LW-1:0]        level_q  [NCH];
	logic [LW-1:0]        target_q [NCH];
	logic signed [CW-1:0] count_q;
	logic [47:0]          out_q;
	logic                 out_valid_q;

	fcvf_pkg::div_req_t div_req;
	fcvf_pkg::div_rsp_t div_rsp;

	logic signed [FW-1:0] frames_in;
	logic signed [CW-1:0] frames_clamped;
	logic                 fade_out;
	logic [NW-1:0]        divisor;
	logic [LW-1:0]        cur_level;
	logic [LW-1:0]        cur_target;
	logic signed [LW:0]   diff;
	logic [LW:0]          diff_mag;
	logic [LW:0]          ceil_q;
	logic [LW-1:0]        new_level;
	logic [LW-1:0]        lvl_shift [NCH];
	logic                 out_free;

	assign frames_in = s_tdata[FW-1:0];

	always_comb begin
		if (frames_in > FW'(fcvf_pkg::FRAME_LIMIT))
			frames_clamped = CW'(fcvf_pkg::FRAME_LIMIT);
		else if (frames_in < -FW'(fcvf_pkg::FRAME_LIMIT))
			frames_clamped = -CW'(fcvf_pkg::FRAME_LIMIT);
		else
			frames_clamped = frames_in[CW-1:0];
	end

	always_comb begin
		logic signed [CW-1:0] neg_count;
		neg_count  = -count_q;
		fade_out   = count_q > 0;
		divisor    = fade_out ? count_q[NW-1:0] : neg_count[NW-1:0];
		cur_level  = level_q[ch_q];
		cur_target = target_q[ch_q];
		diff       = $signed({1'b0, cur_target}) - $signed({1'b0, cur_level});
		diff_mag   = diff[LW] ? (LW+1)'(-diff) : diff;
		ceil_q     = {1'b0, div_rsp.quot} + {{LW{1'b0}}, div_rsp.rem_nz};
		// fade out: floor(l*(n-1)/n) = l - ceil(l/n)
		if (fade_out)
			new_level = cur_level - ceil_q[LW-1:0];
		else if (diff[LW])
			new_level = cur_level - div_rsp.quot;
		else
			new_level = cur_level + div_rsp.quot;
	end

	always_comb begin
		div_req.start    = state_q == ST_LOAD;
		div_req.dividend = fade_out ? cur_level : diff_mag[LW-1:0];
		div_req.divisor  = divisor;
	end

	fcvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_tready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		for (int i = 0; i < NCH; i++)
			lvl_shift[i] = level_q[i] >> fcvf_pkg::FRACTION_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				level_q[i]  <= '0;
				target_q[i] <= fcvf_pkg::TARGET_RESET;
			end
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					fcvf_pkg::REG_TARGET_LL: target_q[0] <= cfg_data;
					fcvf_pkg::REG_TARGET_LR: target_q[1] <= cfg_data;
					fcvf_pkg::REG_TARGET_RR: target_q[2] <= cfg_data;
					fcvf_pkg::REG_TARGET_RL: target_q[3] <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == fcvf_pkg::KIND_START) begin
							count_q <= frames_clamped;
						end else if (count_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							ch_q    <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						level_q[ch_q] <= new_level;
						if (ch_q == 2'(NCH - 1)) begin
							count_q <= fade_out ? count_q - 1'b1 : count_q + 1'b1;
							state_q <= ST_EMIT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					// wait for the output register to be free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free)
			out_q <= {7'd0, count_q, lvl_shift[3][BW-1:0], lvl_shift[2][BW-1:0],
				lvl_shift[1][BW-1:0], lvl_shift[0][BW-1:0]};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIVW)
		else $error("divider finished outside of the wait state");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_EMIT)
		else $error("result raised outside of the emit state");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(fcvf_pkg::FRAME_LIMIT) && count_q >= -CW'(fcvf_pkg::FRAME_LIMIT))
		else $error("fade count beyond the frame limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("pending result dropped before its transfer");

endmodule

FILE: test/tb_four_channel_volume_fader.sv
// testbench for four_channel_volume_fader: directed items and random fades checked against a scoreboard model
// depends on fcvf_pkg and the fader top level
`timescale 1ns / 1ps

module tb_four_channel_volume_fader;

	localparam int NUM_CH        = fcvf_pkg::NUM_CH;
	localparam int BYTE_W        = fcvf_pkg::BYTE_W;
	localparam int LEVEL_W       = fcvf_pkg::LEVEL_W;
	localparam int TARGET_W      = fcvf_pkg::TARGET_W;
	localparam int COUNT_W       = fcvf_pkg::COUNT_W;
	localparam int FRAMES_W      = fcvf_pkg::FRAMES_W;
	localparam int FRAME_LIMIT   = fcvf_pkg::FRAME_LIMIT;
	localparam int FRACTION_BITS = fcvf_pkg::FRACTION_BITS;

	localparam int LEFT_POS = NUM_CH * BYTE_W;  // frames_left position in m_tdata

	typedef struct packed {
		logic [NUM_CH-1:0][BYTE_W-1:0] mix;
		logic [COUNT_W-1:0]            frames_left;
	} frame_result_t;

	class fade_scoreboard;
		logic [LEVEL_W-1:0]  level[NUM_CH];
		logic [TARGET_W-1:0] target[NUM_CH];
		int                  fade_count;
		frame_result_t       expected[$];
		int unsigned         errors, checked, starts, downs, ups, holds;

		function new();
			for (int ch = 0; ch < NUM_CH; ch++) begin
				level[ch]  = '0;
				target[ch] = fcvf_pkg::TARGET_RESET;
			end
			fade_count = 0;
		endfunction

		function void set_target(int ch, logic [TARGET_W-1:0] value);
			target[ch] = value;
		endfunction

		function logic [LEVEL_W-1:0] faded_down(logic [LEVEL_W-1:0] lvl, int n);
			longint unsigned prod;
			prod = longint'(lvl) * longint'(n - 1);
			return LEVEL_W'(prod / longint'(n));
		endfunction

		// signed division truncates toward zero, also when the level sits above target
		function logic [LEVEL_W-1:0] faded_up(logic [LEVEL_W-1:0] lvl,
			logic [TARGET_W-1:0] tgt, int n);
			longint diff, sum;
			diff = longint'(tgt) - longint'(lvl);
			sum  = longint'(lvl) + diff / longint'(n);
			return LEVEL_W'(sum);
		endfunction

		function void note_input(logic kind, logic [FRAMES_W-1:0] frames);
			int            f;
			frame_result_t want;
			if (kind == fcvf_pkg::KIND_START) begin
				f = int'($signed(frames));
				if (f > FRAME_LIMIT)
					f = FRAME_LIMIT;
				if (f < -FRAME_LIMIT)
					f = -FRAME_LIMIT;
				fade_count = f;
				starts++;
				return;
			end
			if (fade_count > 0) begin
				for (int ch = 0; ch < NUM_CH; ch++)
					level[ch] = faded_down(level[ch], fade_count);
				fade_count--;
				downs++;
			end else if (fade_count < 0) begin
				for (int ch = 0; ch < NUM_CH; ch++)
					level[ch] = faded_up(level[ch], target[ch], -fade_count);
				fade_count++;
				ups++;
			end else begin
				holds++;
			end
			for (int ch = 0; ch < NUM_CH; ch++)
				want.mix[ch] = BYTE_W'(level[ch] >> FRACTION_BITS);
			want.frames_left = COUNT_W'(fade_count);
			expected.push_back(want);
		endfunction

		task report_mismatch(string what, int got, int want);
			errors++;
			if (errors <= 30)
				$display("mismatch at result %0d: %s got %0d expected %0d",
					checked, what, got, want);
		endtask

		task check_result(logic [47:0] data);
			frame_result_t want;
			if (expected.size() == 0) begin
				report_mismatch("result transfer with nothing pending", int'(data[40:0]), 0);
				return;
			end
			want = expected.pop_front();
			for (int ch = 0; ch < NUM_CH; ch++)
				if (data[ch*BYTE_W +: BYTE_W] !== want.mix[ch])
					report_mismatch($sformatf("mix byte %0d", ch),
						int'(data[ch*BYTE_W +: BYTE_W]), int'(want.mix[ch]));
			if (data[LEFT_POS +: COUNT_W] !== want.frames_left)
				report_mismatch("frames_left", int'($signed(data[LEFT_POS +: COUNT_W])),
					int'($signed(want.frames_left)));
			checked++;
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;
	logic                 s_tuser   = fcvf_pkg::KIND_FRAME;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [47:0]          m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [1:0]           cfg_index = fcvf_pkg::REG_TARGET_LL;
	logic [18:0]          cfg_data  = '0;
	bit                   quiet     = 1'b0;

	fade_scoreboard sb = new();

	four_channel_volume_fader DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side with random stall bursts
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// valid is left high after a transfer; the next call may drop it for a while, then loads new data
	task automatic send_item(input logic kind, input logic [FRAMES_W-1:0] frames);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, frames};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(kind, frames);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int ch, input logic [18:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_target(ch, value);
	endtask

	task automatic write_targets(input logic [18:0] ll, input logic [18:0] lr,
		input logic [18:0] rr, input logic [18:0] rl);
		write_reg(fcvf_pkg::REG_TARGET_LL, 0, ll);
		write_reg(fcvf_pkg::REG_TARGET_LR, 1, lr);
		write_reg(fcvf_pkg::REG_TARGET_RR, 2, rr);
		write_reg(fcvf_pkg::REG_TARGET_RL, 3, rl);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly complete fades with random length, plus stray frames and restarted fades
	task automatic run_fades(input int items);
		int                  done_items, len, steps, pick;
		logic [FRAMES_W-1:0] fval;
		done_items = 0;
		while (done_items < items) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if ($urandom_range(0, 5) == 0) begin
					fval  = FRAMES_W'($urandom_range(0, 16383));
					steps = $urandom_range(1, 30);
				end else begin
					len   = $urandom_range(1, 24);
					fval  = $urandom_range(0, 1) ? FRAMES_W'(-len) : FRAMES_W'(len);
					steps = (pick < 6) ? len + $urandom_range(0, 2) : $urandom_range(0, len);
				end
				send_item(fcvf_pkg::KIND_START, fval);
				repeat (steps)
					send_item(fcvf_pkg::KIND_FRAME, FRAMES_W'($urandom_range(0, 16383)));
				done_items += steps + 1;
			end else if (pick == 7) begin
				send_item(fcvf_pkg::KIND_FRAME, FRAMES_W'($urandom_range(0, 16383)));
				done_items++;
			end else begin
				send_item(fcvf_pkg::KIND_START, FRAMES_W'($urandom_range(0, 16383)));
				steps = $urandom_range(0, 3);
				repeat (steps)
					send_item(fcvf_pkg::KIND_FRAME, FRAMES_W'($urandom_range(0, 16383)));
				done_items += steps + 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, targets at reset value
		send_item(fcvf_pkg::KIND_FRAME, 14'h0000);   // no fade running
		send_item(fcvf_pkg::KIND_START, 14'h3FFF);   // fade in over one frame jumps to target
		send_item(fcvf_pkg::KIND_FRAME, 14'h0000);
		send_item(fcvf_pkg::KIND_FRAME, 14'h3FFF);   // count back at zero, levels held
		send_item(fcvf_pkg::KIND_START, 14'h0001);   // fade out over one frame drops to zero
		send_item(fcvf_pkg::KIND_FRAME, 14'h2000);
		send_item(fcvf_pkg::KIND_START, 14'h2000);   // most negative, clamped
		send_item(fcvf_pkg::KIND_FRAME, 14'h1FFF);
		send_item(fcvf_pkg::KIND_FRAME, 14'h0000);
		send_item(fcvf_pkg::KIND_START, 14'h1FFF);   // most positive, clamped
		send_item(fcvf_pkg::KIND_FRAME, 14'h0000);
		send_item(fcvf_pkg::KIND_START, 14'h0000);
		send_item(fcvf_pkg::KIND_FRAME, 14'h1555);
		send_item(fcvf_pkg::KIND_START, FRAMES_W'(-3));
		repeat (3) send_item(fcvf_pkg::KIND_FRAME, 14'h2AAA);
		send_item(fcvf_pkg::KIND_START, FRAMES_W'(3));
		repeat (3) send_item(fcvf_pkg::KIND_FRAME, 14'h0000);
		send_item(fcvf_pkg::KIND_START, FRAMES_W'(-2));
		repeat (2) send_item(fcvf_pkg::KIND_FRAME, 14'h0000);

		run_fades(200);
		wait_idle();
		write_targets('0, '0, '0, '0);
		run_fades(230);
		wait_idle();
		write_targets(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF);
		run_fades(230);
		wait_idle();
		write_targets(19'($urandom), 19'($urandom), 19'($urandom), 19'($urandom));
		run_fades(230);
		wait_idle();
		quiet <= 1'b1;
		write_targets('0, 19'h7FFFF, 19'($urandom), fcvf_pkg::TARGET_RESET);
		run_fades(240);

		s_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (sb.expected.size() != 0)
			sb.report_mismatch("results never delivered", 0, sb.expected.size());
		$display("checked %0d frame results: %0d fade-out steps, %0d fade-in steps, %0d held",
			sb.checked, sb.downs, sb.ups, sb.holds);
		$display("%0d fade starts across five target settings, %0d mismatches",
			sb.starts, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/fcvf_pkg.sv
src/fcvf_div.sv
src/four_channel_volume_fader.sv
test/tb_four_channel_volume_fader.sv
